// ===== rtl/qwps_pkg.sv =====
// Shared types and codes of the quota-weighted priority scheduler.
package qwps_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SCHED  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   localparam logic [1:0] CSR_QUOTA_STEP = 2'd0;
   localparam logic [1:0] CSR_QUOTA_BASE = 2'd1;

   localparam logic [3:0] QUOTA_STEP_RESET = 4'd5;
   localparam logic [3:0] QUOTA_BASE_RESET = 4'd1;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  pid;
      logic [1:0]  lvl;
      logic [63:0] ctx;
      logic        ready;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   typedef struct packed {
      logic [3:0] quota_step;
      logic [3:0] quota_base;
   } cfg_type;

endpackage

// ===== rtl/qwps_front.sv =====
// Front end: accepts commands, saturates the level and queues them for the back end.
module qwps_front #(
   parameter int LEVELS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_op,
   input  logic [7:0]            req_pid,
   input  logic [1:0]            req_priority_req,
   input  logic [63:0]           req_context_req,
   input  logic                  req_running_ready,
   output qwps_pkg::cmd_chan_type cmd_out,
   input  logic                  cmd_pop
);
   import qwps_pkg::*;

   cmd_type    entry_ff [2];
   cmd_type    entry_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;
   assign pop  = cmd_pop && (count_ff != 2'd0);

   always_comb begin
      entry_in.op    = req_op;
      entry_in.pid   = req_pid;
      entry_in.ctx   = req_context_req;
      entry_in.ready = req_running_ready;
      if (4'(req_priority_req) >= 4'(LEVELS)) begin
         entry_in.lvl = 2'(LEVELS - 1);
      end else begin
         entry_in.lvl = req_priority_req;
      end
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign cmd_out.valid = (count_ff != 2'd0);
   assign cmd_out.cmd   = entry_ff[rd_ptr_ff];

endmodule

// ===== rtl/qwps_back.sv =====
// Back end: sequencer that runs add, remove and schedule commands on the level queues.
module qwps_back #(
   parameter int LEVELS      = 4,
   parameter int QUEUE_DEPTH = 16,
   parameter int PID_COUNT   = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  qwps_pkg::cmd_chan_type cmd_in,
   output logic                  cmd_pop,
   input  qwps_pkg::cfg_type     cfg,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_running_pid,
   output logic                  rsp_running_valid,
   output logic [63:0]           rsp_resume_context,
   output logic [1:0]            rsp_served_level,
   output logic                  rsp_switched,
   output logic [1:0]            rsp_status
);
   import qwps_pkg::*;

   localparam int LW    = $clog2(LEVELS);
   localparam int HW    = $clog2(QUEUE_DEPTH);
   localparam int FW    = $clog2(QUEUE_DEPTH + 1);
   localparam int SW    = FW + 1;
   localparam int SLOTS = LEVELS * QUEUE_DEPTH;
   localparam int AW    = $clog2(SLOTS);
   localparam int CW    = $clog2(PID_COUNT);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_ADD     = 4'd1;
   localparam logic [3:0] S_RM_RD   = 4'd2;
   localparam logic [3:0] S_RM_CMP  = 4'd3;
   localparam logic [3:0] S_SH_WR   = 4'd4;
   localparam logic [3:0] S_SC_SAVE = 4'd5;
   localparam logic [3:0] S_SC_SEL  = 4'd6;
   localparam logic [3:0] S_SC_POP  = 4'd7;
   localparam logic [3:0] S_CTX_RD  = 4'd8;
   localparam logic [3:0] S_RESP    = 4'd9;

   function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] l,
                                                input logic [HW-1:0] h,
                                                input logic [FW-1:0] pos);
      logic [SW-1:0] s;
      s = SW'(h) + SW'(pos);
      if (s >= SW'(QUEUE_DEPTH)) begin
         s = s - SW'(QUEUE_DEPTH);
      end
      return AW'(l) * AW'(QUEUE_DEPTH) + AW'(s);
   endfunction

   // Remainder by restoring subtraction of shifted copies of the table size.
   function automatic logic [CW-1:0] pid_index(input logic [7:0] p);
      logic [19:0] r;
      r = 20'(p);
      for (int k = 7; k >= 0; k--) begin
         if (r >= (20'(PID_COUNT) << k)) begin
            r = r - (20'(PID_COUNT) << k);
         end
      end
      return CW'(r);
   endfunction

   logic [3:0]    state_ff, state_in;
   cmd_type       cmd_ff, cmd_in_r;
   logic [HW-1:0] head_ff [LEVELS];
   logic [HW-1:0] head_in [LEVELS];
   logic [FW-1:0] fill_ff [LEVELS];
   logic [FW-1:0] fill_in [LEVELS];
   logic [7:0]    count_ff [LEVELS];
   logic [7:0]    count_in [LEVELS];
   logic [7:0]    cur_pid_ff, cur_pid_in;
   logic [LW-1:0] cur_lvl_ff, cur_lvl_in;
   logic          cur_valid_ff, cur_valid_in;
   logic [FW-1:0] pos_ff, pos_in;
   logic [LW-1:0] sel_ff, sel_in;
   logic [1:0]    status_ff, status_in;
   logic          switched_ff, switched_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_pid_ff, rsp_pid_in;
   logic          rsp_rv_ff, rsp_rv_in;
   logic [63:0]   rsp_ctx_ff, rsp_ctx_in;
   logic [1:0]    rsp_lvl_ff, rsp_lvl_in;
   logic          rsp_sw_ff, rsp_sw_in;
   logic [1:0]    rsp_st_ff, rsp_st_in;

   logic [7:0]    queue_mem_ff [SLOTS];
   logic          q_we, q_re;
   logic [AW-1:0] q_waddr, q_raddr;
   logic [7:0]    q_wdata;
   logic [7:0]    q_rdata_ff;

   logic [63:0]   ctx_mem_ff [PID_COUNT];
   logic          c_we, c_re;
   logic [CW-1:0] c_waddr, c_raddr;
   logic [63:0]   c_wdata;
   logic [63:0]   c_rdata_ff;

   logic [LW-1:0] lvl;
   logic          found;
   logic [LW-1:0] found_lvl;
   logic [7:0]    bound;

   assign lvl = LW'(cmd_ff.lvl);

   always_comb begin
      found     = 1'b0;
      found_lvl = '0;
      bound     = '0;
      for (int l = 0; l < LEVELS; l++) begin
         bound = 8'(l) * {4'b0, cfg.quota_step} + {4'b0, cfg.quota_base};
         if (fill_ff[l] != '0 && count_ff[l] <= bound) begin
            found     = 1'b1;
            found_lvl = LW'(l);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in_r     = cmd_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      cur_pid_in   = cur_pid_ff;
      cur_lvl_in   = cur_lvl_ff;
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      sel_in       = sel_ff;
      status_in    = status_ff;
      switched_in  = switched_ff;
      rsp_valid_in = 1'b0;
      rsp_pid_in   = rsp_pid_ff;
      rsp_rv_in    = rsp_rv_ff;
      rsp_ctx_in   = rsp_ctx_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_st_in    = rsp_st_ff;
      cmd_pop      = 1'b0;
      q_we         = 1'b0;
      q_re         = 1'b0;
      q_waddr      = '0;
      q_raddr      = '0;
      q_wdata      = '0;
      c_we         = 1'b0;
      c_re         = 1'b0;
      c_waddr      = '0;
      c_raddr      = '0;
      c_wdata      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_in.valid) begin
               cmd_pop     = 1'b1;
               cmd_in_r    = cmd_in.cmd;
               status_in   = ST_OK;
               switched_in = 1'b0;
               pos_in      = '0;
               unique case (cmd_in.cmd.op)
                  OP_ADD:    state_in = S_ADD;
                  OP_REMOVE: state_in = S_RM_RD;
                  OP_SCHED:  state_in = S_SC_SAVE;
                  default:   state_in = S_CTX_RD;
               endcase
            end
         end
         S_ADD: begin
            c_we    = 1'b1;
            c_waddr = pid_index(cmd_ff.pid);
            c_wdata = cmd_ff.ctx;
            if (fill_ff[lvl] < FW'(QUEUE_DEPTH)) begin
               q_we         = 1'b1;
               q_waddr      = slot_addr(lvl, head_ff[lvl], fill_ff[lvl]);
               q_wdata      = cmd_ff.pid;
               fill_in[lvl] = fill_ff[lvl] + FW'(1);
            end else begin
               status_in = ST_FULL;
            end
            state_in = S_CTX_RD;
         end
         S_RM_RD: begin
            if (pos_ff >= fill_ff[lvl]) begin
               status_in = ST_MISSING;
               state_in  = S_CTX_RD;
            end else begin
               q_re     = 1'b1;
               q_raddr  = slot_addr(lvl, head_ff[lvl], pos_ff);
               state_in = S_RM_CMP;
            end
         end
         S_RM_CMP: begin
            if (q_rdata_ff == cmd_ff.pid) begin
               if (SW'(pos_ff) + SW'(1) < SW'(fill_ff[lvl])) begin
                  q_re     = 1'b1;
                  q_raddr  = slot_addr(lvl, head_ff[lvl], pos_ff + FW'(1));
                  state_in = S_SH_WR;
               end else begin
                  fill_in[lvl] = fill_ff[lvl] - FW'(1);
                  state_in     = S_CTX_RD;
               end
            end else begin
               pos_in   = pos_ff + FW'(1);
               state_in = S_RM_RD;
            end
         end
         S_SH_WR: begin
            // The read data is the entry just behind the one being overwritten.
            q_we    = 1'b1;
            q_waddr = slot_addr(lvl, head_ff[lvl], pos_ff);
            q_wdata = q_rdata_ff;
            if (SW'(pos_ff) + SW'(2) < SW'(fill_ff[lvl])) begin
               q_re    = 1'b1;
               q_raddr = slot_addr(lvl, head_ff[lvl], FW'(SW'(pos_ff) + SW'(2)));
               pos_in  = pos_ff + FW'(1);
            end else begin
               fill_in[lvl] = fill_ff[lvl] - FW'(1);
               state_in     = S_CTX_RD;
            end
         end
         S_SC_SAVE: begin
            if (cur_valid_ff) begin
               c_we    = 1'b1;
               c_waddr = pid_index(cur_pid_ff);
               c_wdata = cmd_ff.ctx;
            end
            if (count_ff[0] == 8'd1) begin
               for (int l = 0; l < LEVELS; l++) begin
                  count_in[l] = '0;
               end
            end
            if (cur_valid_ff && cmd_ff.ready) begin
               if (fill_ff[cur_lvl_ff] < FW'(QUEUE_DEPTH)) begin
                  q_we    = 1'b1;
                  q_waddr = slot_addr(cur_lvl_ff, head_ff[cur_lvl_ff],
                                      fill_ff[cur_lvl_ff]);
                  q_wdata = cur_pid_ff;
                  fill_in[cur_lvl_ff] = fill_ff[cur_lvl_ff] + FW'(1);
               end else begin
                  status_in = ST_FULL;
               end
            end
            state_in = S_SC_SEL;
         end
         S_SC_SEL: begin
            if (found) begin
               q_re     = 1'b1;
               q_raddr  = slot_addr(found_lvl, head_ff[found_lvl], '0);
               sel_in   = found_lvl;
               state_in = S_SC_POP;
            end else begin
               state_in = S_CTX_RD;
            end
         end
         S_SC_POP: begin
            cur_pid_in   = q_rdata_ff;
            cur_lvl_in   = sel_ff;
            cur_valid_in = 1'b1;
            if (head_ff[sel_ff] == HW'(QUEUE_DEPTH - 1)) begin
               head_in[sel_ff] = '0;
            end else begin
               head_in[sel_ff] = head_ff[sel_ff] + HW'(1);
            end
            fill_in[sel_ff] = fill_ff[sel_ff] - FW'(1);
            if (count_ff[sel_ff] != 8'hFF) begin
               count_in[sel_ff] = count_ff[sel_ff] + 8'd1;
            end
            switched_in = 1'b1;
            state_in    = S_CTX_RD;
         end
         S_CTX_RD: begin
            c_re     = 1'b1;
            c_raddr  = pid_index(cur_pid_ff);
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_rv_in    = cur_valid_ff;
            rsp_pid_in   = cur_valid_ff ? cur_pid_ff : 8'd0;
            rsp_lvl_in   = cur_valid_ff ? 2'(cur_lvl_ff) : 2'd0;
            if (cur_valid_ff) begin
               rsp_ctx_in = c_rdata_ff;
            end else if (cmd_ff.op == OP_SCHED) begin
               rsp_ctx_in = cmd_ff.ctx;
            end else begin
               rsp_ctx_in = '0;
            end
            rsp_sw_in = switched_ff;
            rsp_st_in = status_ff;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_pid_ff   <= '0;
         cur_lvl_ff   <= '0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= '0;
            fill_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cur_pid_ff   <= cur_pid_in;
         cur_lvl_ff   <= cur_lvl_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in_r;
      pos_ff      <= pos_in;
      sel_ff      <= sel_in;
      status_ff   <= status_in;
      switched_ff <= switched_in;
      rsp_pid_ff  <= rsp_pid_in;
      rsp_rv_ff   <= rsp_rv_in;
      rsp_ctx_ff  <= rsp_ctx_in;
      rsp_lvl_ff  <= rsp_lvl_in;
      rsp_sw_ff   <= rsp_sw_in;
      rsp_st_ff   <= rsp_st_in;
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem_ff[q_waddr] <= q_wdata;
      end
      if (q_re) begin
         q_rdata_ff <= queue_mem_ff[q_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         ctx_mem_ff[c_waddr] <= c_wdata;
      end
      if (c_re) begin
         c_rdata_ff <= ctx_mem_ff[c_raddr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_running_pid    = rsp_pid_ff;
   assign rsp_running_valid  = rsp_rv_ff;
   assign rsp_resume_context = rsp_ctx_ff;
   assign rsp_served_level   = rsp_lvl_ff;
   assign rsp_switched       = rsp_sw_ff;
   assign rsp_status         = rsp_st_ff;

endmodule

// ===== rtl/quota_weighted_priority_scheduler.sv =====
// Top level of the quota-weighted priority scheduler: configuration registers and the two halves.
// Commands enter through a two-entry queue and run one at a time in a sequencer whose queue
// memory has one read and one write port. After leaving the queue, add passes through S_ADD,
// op 3 goes straight on, and schedule passes through S_SC_SAVE, S_SC_SEL and, when a level
// qualifies, S_SC_POP; remove alternates S_RM_RD and S_RM_CMP over the entries compared, then
// runs S_SH_WR for the entries shifted forward behind the removed one. Every command then
// reads the saved context in S_CTX_RD and registers its result in S_RESP. A command is
// registered in the queue before the sequencer can take it. Each result shows on the rsp_
// ports for one cycle under rsp_valid; the receiver cannot stall it. busy is high only while
// the command queue holds two items.
module quota_weighted_priority_scheduler #(
   parameter int LEVELS      = 4,
   parameter int QUEUE_DEPTH = 16,
   parameter int PID_COUNT   = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_pid,
   input  logic [1:0]  req_priority_req,
   input  logic [63:0] req_context_req,
   input  logic        req_running_ready,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_write_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_running_pid,
   output logic        rsp_running_valid,
   output logic [63:0] rsp_resume_context,
   output logic [1:0]  rsp_served_level,
   output logic        rsp_switched,
   output logic [1:0]  rsp_status
);
   import qwps_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   cmd_chan_type cmd_chan;
   logic         cmd_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_QUOTA_STEP: cfg_in.quota_step = csr_write_data;
            CSR_QUOTA_BASE: cfg_in.quota_base = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quota_step <= QUOTA_STEP_RESET;
         cfg_ff.quota_base <= QUOTA_BASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   qwps_front #(
      .LEVELS(LEVELS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_pid           (req_pid),
      .req_priority_req  (req_priority_req),
      .req_context_req   (req_context_req),
      .req_running_ready (req_running_ready),
      .cmd_out           (cmd_chan),
      .cmd_pop           (cmd_pop)
   );

   qwps_back #(
      .LEVELS      (LEVELS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PID_COUNT   (PID_COUNT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_in             (cmd_chan),
      .cmd_pop            (cmd_pop),
      .cfg                (cfg_ff),
      .rsp_valid          (rsp_valid),
      .rsp_running_pid    (rsp_running_pid),
      .rsp_running_valid  (rsp_running_valid),
      .rsp_resume_context (rsp_resume_context),
      .rsp_served_level   (rsp_served_level),
      .rsp_switched       (rsp_switched),
      .rsp_status         (rsp_status)
   );

endmodule

// ===== rtl/qwps_checker.sv =====
// Port-level assertions for the scheduler and the bind that attaches them.
module qwps_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic [7:0]  rsp_running_pid,
   input logic        rsp_running_valid,
   input logic [1:0]  rsp_served_level,
   input logic        rsp_switched,
   input logic [1:0]  rsp_status
);

   // The sequencer always returns to idle after a result, so strobes never abut.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running_valid |->
         rsp_running_pid == 8'd0 && rsp_served_level == 2'd0 && !rsp_switched)
      else $error("result reports a process while none is running");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switched |-> rsp_running_valid && rsp_status != 2'd2)
      else $error("switch reported without a running process");

   assert property (@(posedge clock) reset |=> !rsp_valid && !busy)
      else $error("block not idle after reset");

endmodule

bind quota_weighted_priority_scheduler qwps_checker u_qwps_checker (
   .clock             (clock),
   .reset             (reset),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_running_pid   (rsp_running_pid),
   .rsp_running_valid (rsp_running_valid),
   .rsp_served_level  (rsp_served_level),
   .rsp_switched      (rsp_switched),
   .rsp_status        (rsp_status)
);

// ===== sim/quota_weighted_priority_scheduler_tb.sv =====
// Testbench for the quota-weighted priority scheduler: random and directed commands checked
// against a cycle-free model of the queues, serve counters and saved contexts.
`timescale 1ns / 1ps

module quota_weighted_priority_scheduler_tb;
   import qwps_pkg::*;

   localparam int LEVELS      = 4;
   localparam int QUEUE_DEPTH = 16;
   localparam int PID_COUNT   = 256;

   typedef struct packed {
      logic [7:0]  running_pid;
      logic        running_valid;
      logic [63:0] resume_context;
      logic [1:0]  served_level;
      logic        switched;
      logic [1:0]  status;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   cmd_type     cmd_drv = '0;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_QUOTA_STEP;
   logic [3:0]  csr_write_data = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_running_pid;
   logic        rsp_running_valid;
   logic [63:0] rsp_resume_context;
   logic [1:0]  rsp_served_level;
   logic        rsp_switched;
   logic [1:0]  rsp_status;

   quota_weighted_priority_scheduler #(
      .LEVELS(LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH), .PID_COUNT(PID_COUNT)
   ) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(cmd_drv.op), .req_pid(cmd_drv.pid), .req_priority_req(cmd_drv.lvl),
      .req_context_req(cmd_drv.ctx), .req_running_ready(cmd_drv.ready),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_running_pid(rsp_running_pid),
      .rsp_running_valid(rsp_running_valid), .rsp_resume_context(rsp_resume_context),
      .rsp_served_level(rsp_served_level), .rsp_switched(rsp_switched),
      .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // Model state of the scheduler.
   logic [7:0]  level_fifo [LEVELS][$];
   logic [7:0]  serve_cnt [LEVELS];
   logic [63:0] saved_ctx [PID_COUNT];
   logic [7:0]  run_pid;
   logic [1:0]  run_level;
   logic        run_valid;
   logic [3:0]  quota_step;
   logic [3:0]  quota_base;

   cmd_type          pending_cmds [$];
   sched_result_type expected_results [$];
   int               mismatches = 0;
   logic             taken = 1'b0;
   int               gap = 0;

   function automatic sched_result_type predict_schedule(cmd_type c);
      sched_result_type r;
      int               k;
      int               idx;
      logic             popped;
      r = '0;
      popped = 1'b0;
      case (c.op)
         OP_ADD: begin
            saved_ctx[c.pid] = c.ctx;
            if (level_fifo[c.lvl].size() >= QUEUE_DEPTH) r.status = ST_FULL;
            else level_fifo[c.lvl].push_back(c.pid);
         end
         OP_REMOVE: begin
            idx = -1;
            for (k = 0; k < level_fifo[c.lvl].size(); k++)
               if (idx < 0 && level_fifo[c.lvl][k] == c.pid) idx = k;
            if (idx < 0) r.status = ST_MISSING;
            else level_fifo[c.lvl].delete(idx);
         end
         OP_SCHED: begin
            if (run_valid) saved_ctx[run_pid] = c.ctx;
            if (serve_cnt[0] == 8'd1)
               for (k = 0; k < LEVELS; k++) serve_cnt[k] = '0;
            if (run_valid && c.ready) begin
               if (level_fifo[run_level].size() >= QUEUE_DEPTH) r.status = ST_FULL;
               else level_fifo[run_level].push_back(run_pid);
            end
            for (k = LEVELS - 1; k >= 0; k--) begin
               if (!popped && level_fifo[k].size() != 0 &&
                   int'(serve_cnt[k]) <= k * int'(quota_step) + int'(quota_base)) begin
                  run_pid = level_fifo[k].pop_front();
                  run_level = k[1:0];
                  run_valid = 1'b1;
                  if (serve_cnt[k] != 8'hFF) serve_cnt[k]++;
                  popped = 1'b1;
               end
            end
            r.switched = popped;
            if (!run_valid) r.resume_context = c.ctx;
         end
         default: ;
      endcase
      if (run_valid) begin
         r.resume_context = saved_ctx[run_pid];
         r.running_pid = run_pid;
         r.served_level = run_level;
      end
      r.running_valid = run_valid;
      return r;
   endfunction

   // Acceptance of commands and checking of results.
   always @(posedge clock) begin
      cmd_type          c;
      sched_result_type got;
      sched_result_type want;
      taken <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         c = cmd_drv;
         expected_results.push_back(predict_schedule(c));
      end
      if (!reset && rsp_valid) begin
         got = '{rsp_running_pid, rsp_running_valid, rsp_resume_context, rsp_served_level,
                 rsp_switched, rsp_status};
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %p", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   // Command driver: presents the oldest pending command, idles a random gap after each transfer.
   always @(negedge clock) begin
      if (start && taken) begin
         void'(pending_cmds.pop_front());
         gap = $urandom_range(0, 5);
         if (gap == 0 && pending_cmds.size() != 0) cmd_drv <= pending_cmds[0];
         else start <= 1'b0;
      end else if (!start && !reset) begin
         if (gap > 0) gap--;
         else if (pending_cmds.size() != 0) begin
            cmd_drv <= pending_cmds[0];
            start <= 1'b1;
         end
      end
   end

   function automatic cmd_type make_cmd(logic [1:0] op, logic [7:0] pid, logic [1:0] lvl,
                                        logic [63:0] ctx, logic ready);
      cmd_type c;
      c.op = op; c.pid = pid; c.lvl = lvl; c.ctx = ctx; c.ready = ready;
      return c;
   endfunction

   function automatic cmd_type random_cmd(int add_weight);
      cmd_type c;
      int      roll;
      roll = $urandom_range(0, 99);
      if (roll < add_weight) c.op = OP_ADD;
      else if (roll < add_weight + 20) c.op = OP_REMOVE;
      else if (roll < 96) c.op = OP_SCHED;
      else c.op = 2'd3;
      // A small id pool makes removes find their target often.
      c.pid = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
      c.lvl = 2'($urandom_range(0, 3));
      c.ctx = {$urandom, $urandom};
      c.ready = ($urandom_range(0, 3) != 0);
      return c;
   endfunction

   task automatic drain_then_write(logic [3:0] step, logic [3:0] base);
      while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_QUOTA_STEP;
      csr_write_data <= step;
      @(negedge clock);
      csr_index <= CSR_QUOTA_BASE;
      csr_write_data <= base;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      quota_step = step;
      quota_base = base;
   endtask

   task automatic random_phase(int n, int add_weight);
      repeat (n) pending_cmds.push_back(random_cmd(add_weight));
   endtask

   initial begin
      int k;
      for (k = 0; k < LEVELS; k++) serve_cnt[k] = '0;
      run_pid = '0;
      run_level = '0;
      run_valid = 1'b0;
      quota_step = QUOTA_STEP_RESET;
      quota_base = QUOTA_BASE_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: nothing running yet, field extremes, every op, full queue, missing id.
      pending_cmds.push_back(make_cmd(OP_SCHED, 8'd0, 2'd0, 64'hDEAD_BEEF_0123_4567, 1'b1));
      pending_cmds.push_back(make_cmd(OP_REMOVE, 8'd7, 2'd2, '0, 1'b0));
      pending_cmds.push_back(make_cmd(2'd3, 8'hFF, 2'd3, '1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_ADD, 8'hFF, 2'd3, '1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_ADD, 8'd0, 2'd0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SCHED, 8'd0, 2'd0, 64'h1, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SCHED, 8'd0, 2'd0, 64'h8000_0000_0000_0000, 1'b1));
      pending_cmds.push_back(make_cmd(OP_REMOVE, 8'hFF, 2'd3, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SCHED, 8'd0, 2'd0, 64'h55, 1'b1));
      pending_cmds.push_back(make_cmd(OP_REMOVE, 8'd0, 2'd0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(2'd3, 8'd0, 2'd0, '0, 1'b0));
      for (k = 0; k < QUEUE_DEPTH; k++)
         pending_cmds.push_back(make_cmd(OP_ADD, 8'(k + 1), 2'd3, {$urandom, $urandom}, 1'b1));
      // The running id goes back into a full level-three queue and is dropped.
      pending_cmds.push_back(make_cmd(OP_SCHED, 8'd0, 2'd0, 64'h77, 1'b1));
      pending_cmds.push_back(make_cmd(OP_ADD, 8'd200, 2'd1, 64'h99, 1'b0));

      random_phase(100, 40);
      drain_then_write(4'd0, 4'd0);
      random_phase(90, 45);
      drain_then_write(4'd15, 4'd15);
      random_phase(90, 40);
      drain_then_write(4'd0, 4'd15);
      random_phase(90, 60);
      drain_then_write(4'd15, 4'd0);
      random_phase(90, 35);
      drain_then_write(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      random_phase(90, 40);

      while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("[quota_weighted_priority_scheduler] OK");
      else
         $display("[quota_weighted_priority_scheduler] ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("[quota_weighted_priority_scheduler] ERROR");
      $finish;
   end

endmodule
